>>> hdl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg: shared types and constants of the command frame decoder
// Holds the frame marks, the command codes, the mnemonic table and the
// queue entry that passes from the front part to the back part.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int NumBytes = 8;
  localparam int NumCmds  = 23;

  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_TWO   = 8'h32;

  localparam logic [3:0] POS_SIZE_ONE = 4'd7;
  localparam logic [3:0] POS_SIZE_TWO = 4'd8;

  localparam logic signed [16:0] VAL_OFFSET = 17'sd45;
  localparam logic signed [16:0] VAL_STOP   = 17'sd40;

  localparam logic [4:0] CMD_NONE = 5'd0;
  localparam logic [4:0] CMD_PWM  = 5'd1;
  localparam logic [4:0] CMD_STA  = 5'd2;
  localparam logic [4:0] CMD_STO  = 5'd3;
  localparam logic [4:0] CMD_CAL  = 5'd4;
  localparam logic [4:0] CMD_CAM  = 5'd5;
  localparam logic [4:0] CMD_CAZ  = 5'd6;
  localparam logic [4:0] CMD_ROL  = 5'd7;
  localparam logic [4:0] CMD_PIT  = 5'd8;
  localparam logic [4:0] CMD_KPP  = 5'd9;
  localparam logic [4:0] CMD_KDP  = 5'd10;
  localparam logic [4:0] CMD_KIP  = 5'd11;
  localparam logic [4:0] CMD_KOP  = 5'd12;
  localparam logic [4:0] CMD_K11  = 5'd13;
  localparam logic [4:0] CMD_K22  = 5'd14;
  localparam logic [4:0] CMD_KTO  = 5'd15;
  localparam logic [4:0] CMD_SFM  = 5'd16;
  localparam logic [4:0] CMD_RST  = 5'd17;
  localparam logic [4:0] CMD_MOL  = 5'd18;
  localparam logic [4:0] CMD_SDT  = 5'd19;
  localparam logic [4:0] CMD_SAL  = 5'd20;
  localparam logic [4:0] CMD_TVY  = 5'd21;
  localparam logic [4:0] CMD_TVR  = 5'd22;
  localparam logic [4:0] CMD_TVP  = 5'd23;

  // Three ASCII letters per command, first letter in the top byte.
  localparam logic [23:0] MNEMONICS [NumCmds] = '{
    24'h70776D, 24'h737461, 24'h73746F, 24'h63616C,
    24'h63616D, 24'h63617A, 24'h726F6C, 24'h706974,
    24'h6B7070, 24'h6B6470, 24'h6B6970, 24'h6B6F70,
    24'h6B3131, 24'h6B3232, 24'h6B746F, 24'h73666D,
    24'h727374, 24'h6D6F6C, 24'h736474, 24'h73616C,
    24'h747679, 24'h747672, 24'h747670
  };

  // A completed frame as it waits in the queue.
  typedef struct packed {
    logic [23:0] mnemonic;
    logic [7:0]  data_lo;
    logic [7:0]  data_hi;
  } cfd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cfd_queue_status_t;

  // Mnemonic lookup; the table entries are distinct, so at most one matches.
  function automatic logic [4:0] cmd_lookup(input logic [23:0] mnemonic);
    logic [4:0] code;
    code = CMD_NONE;
    for (int k = 0; k < NumCmds; k++) begin
      if (mnemonic == MNEMONICS[k]) begin
        code = 5'(k + 1);
      end
    end
    return code;
  endfunction

endpackage

>>> hdl/cfd_front.sv
// ----------------------------------------------------------------------------
// cfd_front: frame walk and classification
// Replays the byte walk over an accepted chunk and pushes completed frames.
// ----------------------------------------------------------------------------
module cfd_front import cfd_pkg::*; (
  input  logic       accept,
  input  logic [7:0] frame_byte_0,
  input  logic [7:0] frame_byte_1,
  input  logic [7:0] frame_byte_2,
  input  logic [7:0] frame_byte_3,
  input  logic [7:0] frame_byte_4,
  input  logic [7:0] frame_byte_5,
  input  logic [7:0] frame_byte_6,
  input  logic [7:0] frame_byte_7,
  output logic       push,
  output cfd_entry_t entry
);

  logic [NumBytes-1:0] is_hash;
  logic [NumBytes-1:0] is_slash;
  logic                complete;

  always_comb begin
    logic [7:0] bytes [NumBytes];
    bytes[0] = frame_byte_0;
    bytes[1] = frame_byte_1;
    bytes[2] = frame_byte_2;
    bytes[3] = frame_byte_3;
    bytes[4] = frame_byte_4;
    bytes[5] = frame_byte_5;
    bytes[6] = frame_byte_6;
    bytes[7] = frame_byte_7;
    for (int j = 0; j < NumBytes; j++) begin
      is_hash[j]  = (bytes[j] == CHAR_HASH);
      is_slash[j] = (bytes[j] == CHAR_SLASH);
    end
  end

  // The first step reads the lead mark and leaves the walk at position 1,
  // disarmed. The remaining seven steps work on a 4-bit position and a flag.
  always_comb begin
    logic [3:0] pos;
    logic [3:0] pos_step;
    logic       armed;
    logic       hash;
    logic       slash;
    logic       size_one;
    logic       size_two;
    size_one = (frame_byte_4 == CHAR_ONE);
    size_two = (frame_byte_4 == CHAR_TWO);
    pos      = 4'd1;
    armed    = 1'b0;
    complete = 1'b0;
    for (int i = 1; i < NumBytes; i++) begin
      hash     = is_hash[pos[2:0]];
      slash    = is_slash[pos[2:0]];
      pos_step = hash ? 4'd1 : pos + 4'd1;
      if (!complete && armed && !hash &&
          ((size_one && pos_step == POS_SIZE_ONE) ||
           (size_two && pos_step == POS_SIZE_TWO))) begin
        complete = 1'b1;
      end
      armed = (armed && !hash) || slash;
      pos   = pos_step;
    end
  end

  assign push           = accept && is_hash[0] && complete;
  assign entry.mnemonic = {frame_byte_1, frame_byte_2, frame_byte_3};
  assign entry.data_lo  = frame_byte_6;
  assign entry.data_hi  = frame_byte_7;

endmodule

>>> hdl/cfd_queue.sv
// ----------------------------------------------------------------------------
// cfd_queue: two-entry queue between front and back
// Holds completed frames until the back part takes them.
// ----------------------------------------------------------------------------
module cfd_queue import cfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cfd_entry_t        push_entry,
  input  logic              pop,
  output cfd_entry_t        head,
  output cfd_queue_status_t status
);

  cfd_entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head         = slots[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    status.full |-> !push)
    else $error("push into a full queue");

endmodule

>>> hdl/cfd_back.sv
// ----------------------------------------------------------------------------
// cfd_back: command lookup and argument formation
// Pops frames, matches the mnemonic, then forms the value and strobes it out.
// ----------------------------------------------------------------------------
module cfd_back import cfd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cfd_entry_t              head,
  input  cfd_queue_status_t       status,
  output logic                    pop,
  output logic                    done,
  output logic [4:0]              command_code,
  output logic signed [16:0]      command_value
);

  logic        s1_valid;
  logic [4:0]  s1_code;
  logic [7:0]  s1_lo;
  logic [7:0]  s1_hi;
  logic signed [16:0] value_next;

  assign pop = !status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= pop;
      done     <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_code <= cmd_lookup(head.mnemonic);
      s1_lo   <= head.data_lo;
      s1_hi   <= head.data_hi;
    end
    if (s1_valid) begin
      command_code  <= s1_code;
      command_value <= value_next;
    end
  end

  always_comb begin
    logic signed [16:0] lo_ext;
    lo_ext = $signed({9'd0, s1_lo});
    unique case (s1_code) inside
      CMD_PWM: value_next = lo_ext;
      CMD_STO: value_next = VAL_STOP;
      CMD_ROL: value_next = VAL_OFFSET - lo_ext;
      CMD_PIT: value_next = lo_ext - VAL_OFFSET;
      CMD_KPP, CMD_KDP, CMD_KIP, CMD_KOP, CMD_K11, CMD_K22, CMD_KTO,
      CMD_SFM, CMD_MOL, CMD_SDT, CMD_SAL:
        value_next = $signed({1'b0, s1_hi, s1_lo});
      CMD_TVY, CMD_TVR, CMD_TVP:
        value_next = $signed({s1_hi[7], s1_hi, s1_lo});
      default: value_next = 17'sd0;
    endcase
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s1_valid))
    else $error("strobe without a looked-up frame");
  a_stop_value: assert property (@(posedge clk) disable iff (rst)
    (done && command_code == CMD_STO) |-> command_value == VAL_STOP)
    else $error("stop command with wrong value");
  a_none_value: assert property (@(posedge clk) disable iff (rst)
    (done && command_code == CMD_NONE) |-> command_value == 17'sd0)
    else $error("unknown command with nonzero value");

endmodule

>>> hdl/command_frame_decoder.sv
// ----------------------------------------------------------------------------
// command_frame_decoder: 8-byte command chunk decoder
// Walks one receive chunk, and for a completed frame emits the command code
// of its mnemonic together with the integer argument of that command.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// input     in         start high, busy low      frame_byte_0 .. frame_byte_7
// result    out        done high for one cycle   command_code, command_value
//
// A chunk can be accepted in every cycle while busy is low. The front part
// classifies it in the cycle of acceptance; a chunk that forms a complete frame
// enters the queue, any other chunk produces no item. The done strobe of a
// completed frame is registered: the entry is written into a queue slot, where
// it is popped and looked up into the first back-part register, and the
// argument is then formed and captured in the output register.
// Reset is synchronous and empties the queue and the pipeline. The receiver
// cannot stall; busy rises only when the queue is full, which does not happen
// while the back part pops an entry in every cycle that one waits.
//
module command_frame_decoder import cfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         frame_byte_0,
  input  logic [7:0]         frame_byte_1,
  input  logic [7:0]         frame_byte_2,
  input  logic [7:0]         frame_byte_3,
  input  logic [7:0]         frame_byte_4,
  input  logic [7:0]         frame_byte_5,
  input  logic [7:0]         frame_byte_6,
  input  logic [7:0]         frame_byte_7,
  output logic               done,
  output logic [4:0]         command_code,
  output logic signed [16:0] command_value
);

  logic              accept;
  logic              push;
  logic              pop;
  cfd_entry_t        push_entry;
  cfd_entry_t        head;
  cfd_queue_status_t status;

  // An item is taken whenever the queue has room.
  assign busy   = status.full;
  assign accept = start && !busy;

  // Front part: replays the byte walk, including the restart from byte 1
  // after every later lead mark, and decides whether the frame completes.
  cfd_front u_front (
    .accept       (accept),
    .frame_byte_0 (frame_byte_0),
    .frame_byte_1 (frame_byte_1),
    .frame_byte_2 (frame_byte_2),
    .frame_byte_3 (frame_byte_3),
    .frame_byte_4 (frame_byte_4),
    .frame_byte_5 (frame_byte_5),
    .frame_byte_6 (frame_byte_6),
    .frame_byte_7 (frame_byte_7),
    .push         (push),
    .entry        (push_entry)
  );

  // The queue keeps only the mnemonic and the two data bytes.
  cfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  // Back part: lookup of the mnemonic, then the argument of the command.
  cfd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .status        (status),
    .pop           (pop),
    .done          (done),
    .command_code  (command_code),
    .command_value (command_value)
  );

endmodule
